// ===== hdl/bsb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsb_pkg
// Types and constants shared by the B-spline basis evaluator.
// ----------------------------------------------------------------------------
package bsb_pkg;
  localparam int MAX_KNOTS_DEF  = 64;
  localparam int MAX_DEGREE_DEF = 7;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int IDX_W = 6;
  localparam int DEG_W = 3;
  localparam int CFG_W = 6;

  localparam logic [0:0] CFG_DEGREE = 1'b0;
  localparam logic [0:0] CFG_LAST   = 1'b1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;
endpackage
`default_nettype wire

// ===== hdl/bsb_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsb_req_if / bsb_res_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface bsb_req_if #(parameter int VW = 17) ();
  logic          valid;
  logic          ready;
  logic          req_type;
  logic [5:0]    knot_index;
  logic [VW-1:0] knot_value;
  logic [VW-1:0] param_u;
  modport source (output valid, req_type, knot_index, knot_value, param_u, input ready);
  modport sink   (input valid, req_type, knot_index, knot_value, param_u, output ready);
endinterface

interface bsb_res_if #(parameter int VW = 17) ();
  logic          valid;
  logic          ready;
  logic [5:0]    basis_index;
  logic [VW-1:0] basis_value;
  logic          status;
  logic          last;
  modport source (output valid, basis_index, basis_value, status, last, input ready);
  modport sink   (input valid, basis_index, basis_value, status, last, output ready);
endinterface
`default_nettype wire

// ===== hdl/bspline_basis_eval.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bspline_basis_eval
// Cox-de Boor basis evaluator: knot table in a synchronous memory, span
// search, triangular recursion through one multiplier and a serial divider.
// ----------------------------------------------------------------------------
// channel  dir  handshake    payload
// req      in   valid/ready  req_type, knot_index, knot_value, param_u
// res      out  valid/ready  basis_index, basis_value, status, last
// cfg      in   cfg_we       cfg_index, cfg_data
// An evaluation reads the end knots, searches the knots one by one for the span,
// then per recursion term (p(p+3)/2 terms) reads four knots, and per division
// (two on inner terms) does one multiply and a serial division, which is skipped
// on a zero term; then it gives one result word per cycle while res is not
// stalled. Reset is synchronous; the knot table is not cleared. A stalled result
// holds its word; a new request is taken after the last word leaves.
// ----------------------------------------------------------------------------
module bspline_basis_eval #(
  parameter int MAX_KNOTS  = bsb_pkg::MAX_KNOTS_DEF,
  parameter int MAX_DEGREE = bsb_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = bsb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  bsb_req_if.sink                  req,
  bsb_res_if.source                res,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [bsb_pkg::CFG_W-1:0] cfg_data
);
  import bsb_pkg::*;

  localparam int VW  = FRAC_BITS + 1;
  localparam int KAW = $clog2(MAX_KNOTS);
  localparam int WAW = $clog2(MAX_DEGREE + 1);
  localparam int SW  = 10;
  localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;
  localparam int QC = $clog2(VW + 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_K0    = 14'b00000000000010,
    S_KM    = 14'b00000000000100,
    S_SRCH  = 14'b00000000001000,
    S_SWAIT = 14'b00000000010000,
    S_INIT  = 14'b00000000100000,
    S_RD    = 14'b00000001000000,
    S_RHOLD = 14'b00000010000000,
    S_RWAIT = 14'b00000100000000,
    S_MUL   = 14'b00001000000000,
    S_DIV   = 14'b00010000000000,
    S_NEXT  = 14'b00100000000000,
    S_OUT   = 14'b01000000000000,
    S_ERR   = 14'b10000000000000
  } state_t;

  state_t state;
  logic [DEG_W-1:0] degree;
  logic [5:0] last_ci;

  logic [VW-1:0] knots [MAX_KNOTS];
  logic [VW-1:0] rdata;
  logic [KAW-1:0] raddr;

  logic [VW-1:0] work [MAX_DEGREE+1];
  logic [VW-1:0] u, k0;
  logic signed [SW-1:0] k, d, i, j, pp, mm, nn;
  logic [2:0]    rphase;   // which knot of the four being read
  logic [VW-1:0] ka, kb, kc, ke;
  logic          half;     // 0 left term, 1 right term
  logic [VW-1:0] left_t;
  logic [2*VW-1:0] rem_q;
  logic [VW:0]   den;
  logic [2*VW-1:0] quo;
  logic [QC+1:0] dcnt;
  logic          term_zero;
  logic [WAW:0]  oj;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready && req.req_type == REQ_WRITE)
      knots[req.knot_index[KAW-1:0]] <= req.knot_value;
    rdata <= knots[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      degree  <= DEG_W'(3);
      last_ci <= 6'd3;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEGREE) degree <= cfg_data[DEG_W-1:0];
      else last_ci <= cfg_data;
    end
  end

  assign req.ready = (state == S_IDLE);

  // knot index of phase: i, i+1, i+d, i+d+1 for the generic term
  logic signed [SW-1:0] rindex;
  always_comb begin
    case (rphase)
      3'd0: rindex = i;
      3'd1: rindex = i + SW'(1);
      3'd2: rindex = i + d;
      default: rindex = i + d + SW'(1);
    endcase
  end

  // signed operand selection for current term
  logic signed [VW+1:0] num_s, den_s;
  logic [VW-1:0] nval;
  logic signed [SW-1:0] w;
  assign w = i - (k - pp);
  always_comb begin
    if (!half) begin
      num_s = $signed({2'b0, u}) - $signed({2'b0, ka});
      den_s = $signed({2'b0, kc}) - $signed({2'b0, ka});
      nval  = (w >= 0 && w <= pp) ? work[w[WAW-1:0]] : '0;
    end else begin
      num_s = $signed({2'b0, ke}) - $signed({2'b0, u});
      den_s = $signed({2'b0, ke}) - $signed({2'b0, kb});
      nval  = (w + 1 >= 0 && w + 1 <= pp) ? work[WAW'(w + 1)] : '0;
    end
  end

  logic [2*VW:0] rem_sh;
  assign rem_sh = {rem_q, quo[2*VW-1]};

  logic [VW-1:0] qsat;
  assign qsat = (quo > {{VW{1'b0}}, ONE}) ? ONE : quo[VW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res.valid <= 1'b0;
      for (int q = 0; q <= MAX_DEGREE; q++) work[q] <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (req.valid && req.req_type == REQ_EVAL) begin
          u  <= req.param_u;
          pp <= SW'(degree);
          nn <= SW'(last_ci);
          mm <= SW'(last_ci) + SW'(degree) + SW'(1);
          if (degree == 0 || 32'(degree) > MAX_DEGREE || last_ci < 6'(degree) ||
              32'(last_ci) + 32'(degree) + 1 > MAX_KNOTS - 1) begin
            state <= S_ERR;
          end else begin
            raddr <= '0; state <= S_K0;
          end
        end
        S_K0: begin
          raddr <= KAW'(mm); state <= S_KM;
        end
        S_KM: begin
          k0 <= rdata; state <= S_SRCH;
        end
        S_SRCH: begin
          if (u == k0) begin
            for (int q = 0; q <= MAX_DEGREE; q++) work[q] <= (q == 0) ? ONE : '0;
            k <= pp; oj <= '0; state <= S_OUT;
          end else if (u == rdata) begin
            for (int q = 0; q <= MAX_DEGREE; q++)
              work[q] <= (q == pp) ? ONE : '0;
            k <= nn; oj <= '0; state <= S_OUT;
          end else if (u < k0 || u > rdata) begin
            state <= S_ERR;
          end else begin
            j <= SW'(1); k <= mm - SW'(1); raddr <= KAW'(1); state <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          state <= S_INIT;
        end
        S_INIT: begin
          // rdata holds knot j
          if (rdata > u || j == mm) begin
            logic signed [SW-1:0] kk;
            kk = (rdata > u) ? j - SW'(1) : mm - SW'(1);
            k <= kk;
            if (kk < pp || kk > nn) state <= S_ERR;
            else begin
              for (int q = 0; q <= MAX_DEGREE; q++)
                work[q] <= (q == pp) ? ONE : '0;
              d <= SW'(1); i <= kk - SW'(1); rphase <= '0; state <= S_RD;
            end
          end else begin
            j <= j + SW'(1); raddr <= KAW'(j + 1); state <= S_SWAIT;
          end
        end
        S_RD: begin
          raddr <= (rindex < 0 || rindex >= MAX_KNOTS) ? '0 : KAW'(rindex);
          state <= S_RHOLD;
        end
        S_RHOLD: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          logic [VW-1:0] kv;
          kv = (rindex < 0 || rindex >= MAX_KNOTS) ? '0 : rdata;
          case (rphase)
            3'd0: ka <= kv;
            3'd1: kb <= kv;
            3'd2: kc <= kv;
            default: ke <= kv;
          endcase
          if (rphase == 3'd3) begin
            half <= (i == k - d) ? 1'b1 : 1'b0;
            left_t <= '0; state <= S_MUL;
          end else begin
            rphase <= rphase + 3'd1; state <= S_RD;
          end
        end
        S_MUL: begin
          term_zero <= (den_s <= 0 || num_s <= 0 || nval == 0);
          quo  <= (2*VW)'(nval) * (2*VW)'(num_s[VW-1:0]);
          den  <= den_s[VW:0];
          rem_q <= '0; dcnt <= '0; state <= S_DIV;
        end
        S_DIV: begin
          if (term_zero || dcnt == (QC+2)'(2*VW)) begin
            logic [VW-1:0] t;
            logic [VW+1:0] sumv;
            t = term_zero ? '0 : qsat;
            sumv = {2'b0, left_t} + {2'b0, t};
            if (!half && i != k) begin
              left_t <= t; half <= 1'b1; state <= S_MUL;
            end else begin
              if (i >= k - d + 1 && i <= k - 1)
                work[WAW'(w)] <= (sumv > (VW+2)'(ONE)) ? ONE : sumv[VW-1:0];
              else if (i == k) work[WAW'(w)] <= t;
              else work[WAW'(w)] <= t;   // first term of the row
              state <= S_NEXT;
            end
          end else begin
            if (rem_sh[2*VW:0] >= (2*VW+1)'(den)) begin
              rem_q <= (2*VW)'(rem_sh - (2*VW+1)'(den));
              quo <= {quo[2*VW-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh[2*VW-1:0];
              quo <= {quo[2*VW-2:0], 1'b0};
            end
            dcnt <= dcnt + 1'b1;
          end
        end
        S_NEXT: begin
          rphase <= '0;
          if (i == k) begin
            if (d == pp) begin oj <= '0; state <= S_OUT; end
            else begin d <= d + SW'(1); i <= k - d - SW'(1); state <= S_RD; end
          end else begin
            i <= i + SW'(1); state <= S_RD;
          end
        end
        S_OUT: begin
          if (!res.valid || res.ready) begin
            if (res.valid && res.last) begin
              res.valid <= 1'b0; state <= S_IDLE;
            end else begin
              res.valid <= 1'b1;
              res.basis_index <= 6'(k - pp + SW'(oj));
              res.basis_value <= work[oj[WAW-1:0]];
              res.status <= ST_OK;
              res.last <= (SW'(oj) == pp);
              oj <= oj + 1'b1;
            end
          end
        end
        S_ERR: begin
          if (!res.valid) begin
            res.valid <= 1'b1; res.basis_index <= '0; res.basis_value <= '0;
            res.status <= ST_ERR; res.last <= 1'b1;
          end else if (res.ready) begin
            res.valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !res.valid) else $error("request taken while a word is pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.basis_value))
    else $error("result word dropped under stall");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == ST_ERR |-> res.last) else $error("error word not last");
`endif
endmodule
`default_nettype wire
